// ----- rtl/core/tbab_pkg.sv -----
package tbab_pkg;

  // row codes carried by row_index
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;
  localparam logic [1:0] ROW_NONE  = 2'd3;

  // q16.16 result range and the wider accumulator range
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [33:0] ACC_MAX = 34'sh1_FFFF_FFFF;
  localparam logic signed [33:0] ACC_MIN = 34'sh2_0000_0000;

  // one input beat: a box extent, one matrix row and the translation
  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] axis_min;
    logic signed [31:0] axis_max;
    logic signed [31:0] mat_c0;
    logic signed [31:0] mat_c1;
    logic signed [31:0] mat_c2;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } tbab_in_t;

  // one result beat: the aligned bounds
  typedef struct packed {
    logic signed [31:0] lo_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_x;
    logic signed [31:0] hi_y;
    logic signed [31:0] hi_z;
    logic               box_empty;
    logic               overflow;
  } tbab_out_t;

  // control from the pipeline to each column
  typedef struct packed {
    logic prod_en;
    logic acc_en;
    logic seed;
  } tbab_col_ctrl_t;

  // status from each column back to the pipeline
  typedef struct packed {
    logic sat_upd;
    logic sat_out;
  } tbab_col_stat_t;

  // saturate a 34 bit accumulator to the q16.16 range
  function automatic logic signed [31:0] clamp_q(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

  // true where the accumulator lies outside the q16.16 range
  function automatic logic clamp_hit(input logic signed [33:0] v);
    return !(v[33:31] == 3'b000 || v[33:31] == 3'b111);
  endfunction

endpackage

// ----- rtl/core/tbab_col.sv -----
module tbab_col
  import tbab_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbab_col_ctrl_t     ctrl_i,
  input  logic signed [31:0] bmin_i,
  input  logic signed [31:0] bmax_i,
  input  logic signed [31:0] coef_i,
  input  logic signed [31:0] seed_i,
  output tbab_col_stat_t     stat_o,
  output logic signed [31:0] lo_o,
  output logic signed [31:0] hi_o
);

  logic signed [63:0] pmin_q, pmax_q;
  logic signed [63:0] pmin_d, pmax_d;
  logic signed [63:0] shmin, shmax;
  logic signed [31:0] qmin, qmax, prod_lo, prod_hi;
  logic               satmin, satmax, satlo, sathi;
  logic signed [33:0] lo_q, hi_q, lo_d, hi_d;
  logic signed [33:0] lo_base, hi_base;
  logic signed [34:0] lo_sum, hi_sum;

  // the two products of this column
  assign pmin_d = bmin_i * coef_i;
  assign pmax_d = bmax_i * coef_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      pmin_q <= pmin_d;
      pmax_q <= pmax_d;
    end
  end

  // drop the fraction bits, rounding toward minus infinity
  assign shmin = pmin_q >>> FRAC_BITS;
  assign shmax = pmax_q >>> FRAC_BITS;

  // saturate each product to q16.16
  always_comb begin
    satmin = !((&shmin[63:31]) || !(|shmin[63:31]));
    satmax = !((&shmax[63:31]) || !(|shmax[63:31]));
    qmin   = satmin ? (shmin[63] ? Q_MIN : Q_MAX) : shmin[31:0];
    qmax   = satmax ? (shmax[63] ? Q_MIN : Q_MAX) : shmax[31:0];
  end

  // order the products
  always_comb begin
    if (qmin < qmax) begin
      prod_lo = qmin;
      prod_hi = qmax;
    end else begin
      prod_lo = qmax;
      prod_hi = qmin;
    end
  end

  // accumulate with saturation to the 34 bit range
  always_comb begin
    lo_base = ctrl_i.seed ? 34'(seed_i) : lo_q;
    hi_base = ctrl_i.seed ? 34'(seed_i) : hi_q;
    lo_sum  = 35'(lo_base) + 35'(prod_lo);
    hi_sum  = 35'(hi_base) + 35'(prod_hi);
    satlo   = lo_sum[34] != lo_sum[33];
    sathi   = hi_sum[34] != hi_sum[33];
    lo_d    = satlo ? (lo_sum[34] ? ACC_MIN : ACC_MAX) : lo_sum[33:0];
    hi_d    = sathi ? (hi_sum[34] ? ACC_MIN : ACC_MAX) : hi_sum[33:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else if (ctrl_i.acc_en) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // status and clamped view of the accumulators
  assign stat_o.sat_upd = satmin | satmax | satlo | sathi;
  assign stat_o.sat_out = clamp_hit(lo_q) | clamp_hit(hi_q);
  assign lo_o           = clamp_q(lo_q);
  assign hi_o           = clamp_q(hi_q);

endmodule

// ----- rtl/core/transformed_box_aligned_bounds.sv -----
// path: a row beat passes the input, product and accumulator registers; a last row's result
//   then goes to the output register; throughput: one row beat per cycle while no stage stalls,
//   with three column lanes each holding two 32x32 multipliers
// reset: accumulators, raw extents and the empty and saturation flags clear to zero,
//   the pipeline empties and no result is pending
module transformed_box_aligned_bounds
  import tbab_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tbab_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tbab_out_t out_data_o
);

  logic               in_acc;
  logic               a_valid_q, a_valid_d, a_go;
  tbab_in_t           a_q;
  logic               b_valid_q, b_valid_d, b_go;
  logic [1:0]         b_row_q;
  logic signed [31:0] b_shift_q [3];
  logic signed [31:0] b_lo_q, b_hi_q;
  logic               b_empty_q;
  logic               c_valid_q, c_valid_d, c_go;
  logic               out_valid_q, out_valid_d, out_free;
  tbab_out_t          out_q, out_d;

  logic signed [31:0] raw_lo_q [3];
  logic signed [31:0] raw_hi_q [3];
  logic               empty_q, sat_q;

  tbab_col_ctrl_t     col_ctrl;
  tbab_col_stat_t     col_stat [3];
  logic signed [31:0] a_coef [3];
  logic signed [31:0] col_lo [3];
  logic signed [31:0] col_hi [3];
  logic               sat_upd_any, sat_out_any;

  // stage handshakes, each stage moves when the one after it has room
  assign out_free   = !out_valid_q || !out_stall_i;
  assign c_go       = c_valid_q && out_free;
  assign b_go       = b_valid_q && (!c_valid_q || c_go);
  assign a_go       = a_valid_q && (!b_valid_q || b_go);
  assign in_stall_o = a_valid_q && !a_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    a_valid_d   = in_acc ? (in_data_i.row_index != ROW_NONE) : (a_valid_q && !a_go);
    b_valid_d   = a_go || (b_valid_q && !b_go);
    c_valid_d   = (b_go && b_row_q == ROW_LAST) || (c_valid_q && !c_go);
    out_valid_d = c_go || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      b_valid_q   <= b_valid_d;
      c_valid_q   <= c_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= in_data_i;
    end
  end

  // side data that travels with the products
  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_row_q      <= a_q.row_index;
      b_shift_q[0] <= a_q.shift_x;
      b_shift_q[1] <= a_q.shift_y;
      b_shift_q[2] <= a_q.shift_z;
      b_lo_q       <= a_q.axis_min;
      b_hi_q       <= a_q.axis_max;
      b_empty_q    <= a_q.axis_min > a_q.axis_max;
    end
  end

  // column lanes
  assign a_coef[0]        = a_q.mat_c0;
  assign a_coef[1]        = a_q.mat_c1;
  assign a_coef[2]        = a_q.mat_c2;
  assign col_ctrl.prod_en = a_go;
  assign col_ctrl.acc_en  = b_go;
  assign col_ctrl.seed    = b_row_q == ROW_FIRST;

  for (genvar j = 0; j < 3; j++) begin : g_col
    tbab_col #(
      .FRAC_BITS(FRAC_BITS)
    ) u_col (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (col_ctrl),
      .bmin_i (a_q.axis_min),
      .bmax_i (a_q.axis_max),
      .coef_i (a_coef[j]),
      .seed_i (b_shift_q[j]),
      .stat_o (col_stat[j]),
      .lo_o   (col_lo[j]),
      .hi_o   (col_hi[j])
    );
  end

  assign sat_upd_any = col_stat[0].sat_upd | col_stat[1].sat_upd | col_stat[2].sat_upd;
  assign sat_out_any = col_stat[0].sat_out | col_stat[1].sat_out | col_stat[2].sat_out;

  // sticky flags and raw extents, the first row clears the flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b0;
      sat_q   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        raw_lo_q[k] <= '0;
        raw_hi_q[k] <= '0;
      end
    end else if (b_go) begin
      empty_q <= (empty_q && !col_ctrl.seed) || b_empty_q;
      sat_q   <= (sat_q && !col_ctrl.seed) || sat_upd_any;
      for (int k = 0; k < 3; k++) begin
        if (b_row_q == 2'(k)) begin
          raw_lo_q[k] <= b_lo_q;
          raw_hi_q[k] <= b_hi_q;
        end
      end
    end
  end

  // result beat, raw box when some axis was empty
  always_comb begin
    if (empty_q) begin
      out_d.lo_x      = raw_lo_q[0];
      out_d.lo_y      = raw_lo_q[1];
      out_d.lo_z      = raw_lo_q[2];
      out_d.hi_x      = raw_hi_q[0];
      out_d.hi_y      = raw_hi_q[1];
      out_d.hi_z      = raw_hi_q[2];
      out_d.box_empty = 1'b1;
      out_d.overflow  = 1'b0;
    end else begin
      out_d.lo_x      = col_lo[0];
      out_d.lo_y      = col_lo[1];
      out_d.lo_z      = col_lo[2];
      out_d.hi_x      = col_hi[0];
      out_d.hi_y      = col_hi[1];
      out_d.hi_z      = col_hi[2];
      out_d.box_empty = 1'b0;
      out_d.overflow  = sat_q | sat_out_any;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (c_go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/sv/tb_transformed_box_aligned_bounds.sv -----
module tb_transformed_box_aligned_bounds;
  timeunit 1ns;
  timeprecision 1ps;
  import tbab_pkg::*;

  localparam int          FRAC_BITS  = 16;
  localparam logic [1:0]  ROW_MID    = 2'd1;
  localparam longint      Q_LO       = longint'(Q_MIN);
  localparam longint      Q_HI       = longint'(Q_MAX);
  localparam longint      ACC_LO     = longint'(ACC_MIN);
  localparam longint      ACC_HI     = longint'(ACC_MAX);
  localparam int          QUIET_LIMIT = 4000;
  localparam int          BACKLOG_HOLD = 300;
  localparam int          PHASE_ITEMS  = 500;

  typedef enum int {MAG_SMALL, MAG_EDGE, MAG_FULL} mag_e;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  tbab_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  tbab_out_t out_data_o;

  transformed_box_aligned_bounds #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // row beats waiting to be driven, bounds waiting to come out
  tbab_in_t  row_backlog[$];
  tbab_out_t bounds_due[$];

  // own copy of the accumulator state
  longint      low_acc[3];
  longint      high_acc[3];
  logic [31:0] extent_lo[3];
  logic [31:0] extent_hi[3];
  bit          empty_flag;
  bit          sat_flag;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit run_done = 0;
  int errors = 0;
  int rows_queued = 0;
  int rows_taken = 0;
  int bounds_seen = 0;
  int empty_seen_cnt = 0;
  int sat_seen_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // saturate to a range and note it
  function automatic longint limit(input longint v, input longint lo, input longint hi,
                                   inout bit flag);
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // full product scaled back, floor rounding
  function automatic longint scaled_prod(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic void predict_bounds(input tbab_in_t beat, output bit emits,
                                         output tbab_out_t res);
    int                 r;
    longint             pa, pb, sm, lg, t;
    logic signed [31:0] coef[3];
    logic [31:0]        lo_v[3], hi_v[3];
    bit                 f;
    emits = 1'b0;
    res = '0;
    if (beat.row_index == ROW_NONE) return;
    r = int'(beat.row_index);
    coef[0] = beat.mat_c0;
    coef[1] = beat.mat_c1;
    coef[2] = beat.mat_c2;
    // row 0 restarts from the translation
    if (beat.row_index == ROW_FIRST) begin
      empty_flag = 1'b0;
      sat_flag = 1'b0;
      low_acc[0] = longint'(beat.shift_x);
      low_acc[1] = longint'(beat.shift_y);
      low_acc[2] = longint'(beat.shift_z);
      for (int j = 0; j < 3; j++) high_acc[j] = low_acc[j];
    end
    extent_lo[r] = beat.axis_min;
    extent_hi[r] = beat.axis_max;
    if (beat.axis_min > beat.axis_max) empty_flag = 1'b1;
    // smaller product to the low sum, larger to the high sum
    for (int j = 0; j < 3; j++) begin
      pa = limit(scaled_prod(beat.axis_min, coef[j]), Q_LO, Q_HI, sat_flag);
      pb = limit(scaled_prod(beat.axis_max, coef[j]), Q_LO, Q_HI, sat_flag);
      sm = (pa < pb) ? pa : pb;
      lg = (pa < pb) ? pb : pa;
      low_acc[j] = limit(low_acc[j] + sm, ACC_LO, ACC_HI, sat_flag);
      high_acc[j] = limit(high_acc[j] + lg, ACC_LO, ACC_HI, sat_flag);
    end
    if (beat.row_index != ROW_LAST) return;
    emits = 1'b1;
    if (empty_flag) begin
      lo_v = extent_lo;
      hi_v = extent_hi;
      res.box_empty = 1'b1;
      res.overflow = 1'b0;
    end else begin
      f = sat_flag;
      for (int j = 0; j < 3; j++) begin
        t = limit(low_acc[j], Q_LO, Q_HI, f);
        lo_v[j] = t[31:0];
        t = limit(high_acc[j], Q_LO, Q_HI, f);
        hi_v[j] = t[31:0];
      end
      res.box_empty = 1'b0;
      res.overflow = f;
    end
    res.lo_x = lo_v[0];
    res.lo_y = lo_v[1];
    res.lo_z = lo_v[2];
    res.hi_x = hi_v[0];
    res.hi_y = hi_v[1];
    res.hi_z = hi_v[2];
  endfunction

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_bounds(input tbab_out_t want, input tbab_out_t got);
    field_check("lo_x", want.lo_x, got.lo_x);
    field_check("lo_y", want.lo_y, got.lo_y);
    field_check("lo_z", want.lo_z, got.lo_z);
    field_check("hi_x", want.hi_x, got.hi_x);
    field_check("hi_y", want.hi_y, got.hi_y);
    field_check("hi_z", want.hi_z, got.hi_z);
    field_check("box_empty", 32'(want.box_empty), 32'(got.box_empty));
    field_check("overflow", 32'(want.overflow), 32'(got.overflow));
  endtask

  // sender: next beat from the backlog, held while stalled
  always @(posedge clk_i or negedge rst_ni) begin : drive_rows
    bit        emits;
    tbab_out_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rows_taken++;
        predict_bounds(in_data_i, emits, res);
        if (emits) bounds_due.push_back(res);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (row_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= row_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: check each bounds beat, stall at random or for a long hold
  always @(posedge clk_i or negedge rst_ni) begin : watch_bounds
    tbab_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        bounds_seen++;
        if (bounds_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected bounds beat, expected none, actual %h", $time,
                   out_data_o);
        end else begin
          want = bounds_due.pop_front();
          if (want.box_empty) empty_seen_cnt++;
          if (want.overflow) sat_seen_cnt++;
          check_bounds(want, out_data_o);
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if (rst_ni && !run_done) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("** transformed_box_aligned_bounds: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic tbab_in_t mk_row(input logic [1:0] r, input logic [31:0] mn,
                                      input logic [31:0] mx, input logic [31:0] c0,
                                      input logic [31:0] c1, input logic [31:0] c2,
                                      input logic [31:0] sx, input logic [31:0] sy,
                                      input logic [31:0] sz);
    tbab_in_t b;
    b.row_index = r;
    b.axis_min = mn;
    b.axis_max = mx;
    b.mat_c0 = c0;
    b.mat_c1 = c1;
    b.mat_c2 = c2;
    b.shift_x = sx;
    b.shift_y = sy;
    b.shift_z = sz;
    return b;
  endfunction

  task automatic queue_row(input tbab_in_t b);
    row_backlog.push_back(b);
    if (b.row_index != ROW_NONE) rows_queued++;
  endtask

  function automatic logic [31:0] rand_word(input mag_e m);
    logic [31:0] w;
    case (m)
      MAG_SMALL: w = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      MAG_EDGE: begin
        case ($urandom_range(7))
          0: w = 32'h0000_0000;
          1: w = 32'h0000_0001;
          2: w = 32'hFFFF_FFFF;
          3: w = 32'h7FFF_FFFF;
          4: w = 32'h8000_0000;
          5: w = 32'h0001_0000;
          6: w = 32'hFFFF_0000;
          default: w = 32'h0000_8000;
        endcase
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] word_of_box(input mag_e m);
    if (m == MAG_EDGE && $urandom_range(1)) return rand_word(MAG_SMALL);
    return rand_word(m);
  endfunction

  // one random row, extents mostly ordered
  task automatic queue_rand_row(input logic [1:0] r, input mag_e m);
    logic [31:0] a, b, t;
    a = word_of_box(m);
    b = word_of_box(m);
    if ($urandom_range(9) != 0 && $signed(a) > $signed(b)) begin
      t = a;
      a = b;
      b = t;
    end
    queue_row(mk_row(r, a, b, word_of_box(m), word_of_box(m), word_of_box(m),
                     word_of_box(m), word_of_box(m), word_of_box(m)));
  endtask

  task automatic queue_random(input int count);
    int   start;
    int   pick;
    mag_e m;
    start = rows_queued;
    while (rows_queued - start < count) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: m = MAG_SMALL;
        6, 7: m = MAG_EDGE;
        default: m = MAG_FULL;
      endcase
      if (pick < 85) begin
        queue_rand_row(ROW_FIRST, m);
        queue_rand_row(ROW_MID, m);
        queue_rand_row(ROW_LAST, m);
      end else if (pick < 95) begin
        queue_rand_row(2'($urandom_range(2)), m);
      end else begin
        queue_rand_row(ROW_NONE, MAG_FULL);
      end
    end
  endtask

  task automatic drain_all();
    @(negedge clk_i);
    while (row_backlog.size() > 0 || in_valid_i || bounds_due.size() > 0) @(negedge clk_i);
  endtask

  task automatic queue_directed();
    // rows 1 and 2 straight after reset, no row 0
    queue_row(mk_row(ROW_MID, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0,
                     32'hFFFF_0000, 32'h1234_5678, 32'h0, 32'h0));
    queue_row(mk_row(ROW_LAST, 32'hFFFF_0000, 32'h0003_0000, 32'h0, 32'h0002_0000,
                     32'h0000_8000, 32'h0, 32'h0, 32'h0));
    // invalid row leaves the state alone
    queue_row(mk_row(ROW_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    // identity matrix, unit box, offset by (1, 2, 3)
    queue_row(mk_row(ROW_FIRST, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0,
                     32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
    queue_row(mk_row(ROW_MID, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0,
                     32'h0, 32'h0, 32'h0));
    queue_row(mk_row(ROW_LAST, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000,
                     32'h0, 32'h0, 32'h0));
    // extreme extents and matrix: products saturate
    queue_row(mk_row(ROW_FIRST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    queue_row(mk_row(ROW_MID, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
    queue_row(mk_row(ROW_LAST, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h0, 32'h0, 32'h0));
    // negative products floor: minus half an lsb becomes minus one
    queue_row(mk_row(ROW_FIRST, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000, 32'hFFFF_8000,
                     32'h0000_0001, 32'h0, 32'h0, 32'h0));
    queue_row(mk_row(ROW_MID, 32'hFFFF_FFFD, 32'h0000_0003, 32'h0000_4000, 32'hFFFF_C000,
                     32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
    queue_row(mk_row(ROW_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                     32'h0000_8000, 32'h0, 32'h0, 32'h0));
    // empty box on the middle axis returns the raw extents
    queue_row(mk_row(ROW_FIRST, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    queue_row(mk_row(ROW_MID, 32'h0005_0000, 32'h0004_0000, 32'h0, 32'h0001_0000, 32'h0,
                     32'h0, 32'h0, 32'h0));
    queue_row(mk_row(ROW_LAST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0001_0000,
                     32'h0, 32'h0, 32'h0));
    // sums leave the output range without any product saturating
    queue_row(mk_row(ROW_FIRST, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
                     32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    queue_row(mk_row(ROW_MID, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
                     32'h0, 32'h0, 32'h0, 32'h0));
    queue_row(mk_row(ROW_LAST, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    // repeated row 2 drives the accumulators into their own limit
    queue_row(mk_row(ROW_FIRST, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    repeat (4) begin
      queue_row(mk_row(ROW_LAST, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h0001_0000, 32'h0, 32'h0, 32'h0));
    end
  endtask

  initial begin
    for (int j = 0; j < 3; j++) begin
      low_acc[j] = 0;
      high_acc[j] = 0;
      extent_lo[j] = '0;
      extent_hi[j] = '0;
    end
    empty_flag = 1'b0;
    sat_flag = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows at full rate
    queue_directed();
    drain_all();

    // full rate, with a long receiver hold so the pipeline backs up
    hold_left = BACKLOG_HOLD;
    queue_random(PHASE_ITEMS);
    drain_all();

    // sparse sender
    send_idle_pct = 87;
    recv_stall_pct = 0;
    queue_random(PHASE_ITEMS);
    drain_all();

    // heavy receiver stall
    send_idle_pct = 0;
    recv_stall_pct = 87;
    queue_random(PHASE_ITEMS);
    drain_all();

    // both sides idling
    send_idle_pct = 33;
    recv_stall_pct = 33;
    queue_random(PHASE_ITEMS);
    drain_all();

    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    run_done = 1'b1;
    if (bounds_due.size() != 0) begin
      errors++;
      $display("%0t: %0d bounds beats never arrived", $time, bounds_due.size());
    end
    $display("rows accepted: %0d, bounds checked: %0d (empty boxes %0d, saturated %0d)",
             rows_taken, bounds_seen, empty_seen_cnt, sat_seen_cnt);
    $display("phases: directed, full rate with backlog, sparse sender, stalling receiver,"
             , " both idling; %0d mismatches", errors);
    if (errors == 0) begin
      $display("** transformed_box_aligned_bounds: PASSED **");
    end else begin
      $display("** transformed_box_aligned_bounds: FAILED **");
    end
    $finish;
  end

endmodule
